// ===== hdl/balance_robot_cascade_pid_core_macros.svh =====
// Assertion shorthands for the balance core checker.
`ifndef BALANCE_ROBOT_CASCADE_PID_CORE_MACROS_SVH
`define BALANCE_ROBOT_CASCADE_PID_CORE_MACROS_SVH

// Clocked property, off while reset is high.
`define BRCP_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen.
`define BRCP_ASSERT_NEVER(label, cond, msg) \
  `BRCP_ASSERT_CLK(label, !(cond), msg)

`endif

// ===== hdl/brcp_pkg.sv =====
package brcp_pkg;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Datapath widths
  localparam int ERR_W  = 18;
  localparam int FE_W   = 18;
  localparam int SI_W   = 16;
  localparam int ST_W   = 5;
  localparam int TT_W   = 9;
  localparam int VSUM_W = 27;
  localparam int VX_W   = 24;
  localparam int VQ_W   = 20;
  localparam int VEL_W  = 21;
  localparam int DIFF_W = 30;
  localparam int TURN_W = 21;
  localparam int UP_W   = 33;
  localparam int MIX_W  = 34;
  localparam int DRV_W  = 16;

  localparam int ADDR_W   = 5;
  localparam int IN_W     = 104;
  localparam int OUT_W    = 32;

  localparam logic [15:0] NEAR_DISTANCE = 16'd50;
  localparam int          TURN_STEP     = 30;
  localparam logic [8:0]  ALPHA_ONE     = 9'd256;

  // trunc(|n| / 51200) = trunc((|n| >> 11) / 25); /25 by reciprocal, one correction
  localparam int          VEL_PRE_SHIFT = 11;
  localparam int          RECIP_SHIFT   = 29;
  localparam logic [24:0] VEL_RECIP     = 25'd21474836;
  localparam logic [VX_W-1:0] VEL_DIV   = VX_W'(25);

  typedef enum logic [2:0] {
    REG_UPRIGHT_KP     = 3'd0,
    REG_UPRIGHT_KD     = 3'd1,
    REG_SPEED_KP       = 3'd2,
    REG_FILTER_ALPHA   = 3'd3,
    REG_TURN_KP        = 3'd4,
    REG_TURN_KD        = 3'd5,
    REG_BALANCE_OFFSET = 3'd6,
    REG_PWM_LIMIT      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [17:0]        upright_kp;
    logic [11:0]        upright_kd;
    logic [9:0]         speed_kp;
    logic [8:0]         filter_alpha;
    logic [15:0]        turn_kp;
    logic [11:0]        turn_kd;
    logic signed [16:0] balance_offset;
    logic [14:0]        pwm_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    upright_kp:     18'd30720,
    upright_kd:     12'd192,
    speed_kp:       10'd282,
    filter_alpha:   9'd179,
    turn_kp:        16'd2560,
    turn_kd:        12'd154,
    balance_offset: 17'sd0,
    pwm_limit:      15'd7200
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FE0,
    ST_FE1,
    ST_FE,
    ST_SI,
    ST_VEL0,
    ST_VEL1,
    ST_VEL2,
    ST_VEL3,
    ST_VEL4,
    ST_DIFF,
    ST_UP0,
    ST_UP1,
    ST_UP2,
    ST_MIX
  } step_t;

  typedef struct packed {
    step_t step;
    logic  ready;
    logic  load;
  } ctrl_t;

  // Signed divide by 2**sh, truncating toward zero
  function automatic logic signed [PROD_W-1:0] sdiv_pow2(
    input logic signed [PROD_W-1:0] v,
    input logic [5:0]               sh
  );
    logic signed [PROD_W-1:0] bias;
    bias = v[PROD_W-1] ? $signed((PROD_W'(1) << sh) - PROD_W'(1)) : '0;
    return (v + bias) >>> sh;
  endfunction

endpackage

// ===== hdl/brcp_regs.sv =====
module brcp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brcp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output brcp_pkg::cfg_t               cfg
);

  brcp_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = brcp_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= brcp_pkg::CFG_RESET;
    end else if (wr) begin
      case (idx)
        brcp_pkg::REG_UPRIGHT_KP:     cfg.upright_kp     <= pwdata[17:0];
        brcp_pkg::REG_UPRIGHT_KD:     cfg.upright_kd     <= pwdata[11:0];
        brcp_pkg::REG_SPEED_KP:       cfg.speed_kp       <= pwdata[9:0];
        brcp_pkg::REG_FILTER_ALPHA:   cfg.filter_alpha   <= pwdata[8:0];
        brcp_pkg::REG_TURN_KP:        cfg.turn_kp        <= pwdata[15:0];
        brcp_pkg::REG_TURN_KD:        cfg.turn_kd        <= pwdata[11:0];
        brcp_pkg::REG_BALANCE_OFFSET: cfg.balance_offset <= $signed(pwdata[16:0]);
        brcp_pkg::REG_PWM_LIMIT:      cfg.pwm_limit      <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      brcp_pkg::REG_UPRIGHT_KP:     prdata = 32'(cfg.upright_kp);
      brcp_pkg::REG_UPRIGHT_KD:     prdata = 32'(cfg.upright_kd);
      brcp_pkg::REG_SPEED_KP:       prdata = 32'(cfg.speed_kp);
      brcp_pkg::REG_FILTER_ALPHA:   prdata = 32'(cfg.filter_alpha);
      brcp_pkg::REG_TURN_KP:        prdata = 32'(cfg.turn_kp);
      brcp_pkg::REG_TURN_KD:        prdata = 32'(cfg.turn_kd);
      brcp_pkg::REG_BALANCE_OFFSET: prdata = 32'(cfg.balance_offset);
      brcp_pkg::REG_PWM_LIMIT:      prdata = 32'(cfg.pwm_limit);
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== hdl/brcp_mul.sv =====
module brcp_mul (
  input  logic                                clk,
  input  logic signed [brcp_pkg::MUL_A_W-1:0] a,
  input  logic signed [brcp_pkg::MUL_B_W-1:0] b,
  output logic signed [brcp_pkg::PROD_W-1:0]  p
);

  // one registered signed multiply per cycle
  always_ff @(posedge clk) begin
    p <= brcp_pkg::PROD_W'(a) * brcp_pkg::PROD_W'(b);
  end

endmodule

// ===== hdl/brcp_ctrl.sv =====
module brcp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            out_free,
  output brcp_pkg::ctrl_t ctrl
);

  brcp_pkg::step_t step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= brcp_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    case (step)
      brcp_pkg::ST_IDLE: step_next = start ? brcp_pkg::ST_FE0 : brcp_pkg::ST_IDLE;
      brcp_pkg::ST_FE0:  step_next = brcp_pkg::ST_FE1;
      brcp_pkg::ST_FE1:  step_next = brcp_pkg::ST_FE;
      brcp_pkg::ST_FE:   step_next = brcp_pkg::ST_SI;
      brcp_pkg::ST_SI:   step_next = brcp_pkg::ST_VEL0;
      brcp_pkg::ST_VEL0: step_next = brcp_pkg::ST_VEL1;
      brcp_pkg::ST_VEL1: step_next = brcp_pkg::ST_VEL2;
      brcp_pkg::ST_VEL2: step_next = brcp_pkg::ST_VEL3;
      brcp_pkg::ST_VEL3: step_next = brcp_pkg::ST_VEL4;
      brcp_pkg::ST_VEL4: step_next = brcp_pkg::ST_DIFF;
      brcp_pkg::ST_DIFF: step_next = brcp_pkg::ST_UP0;
      brcp_pkg::ST_UP0:  step_next = brcp_pkg::ST_UP1;
      brcp_pkg::ST_UP1:  step_next = brcp_pkg::ST_UP2;
      brcp_pkg::ST_UP2:  step_next = brcp_pkg::ST_MIX;
      brcp_pkg::ST_MIX:  step_next = out_free ? brcp_pkg::ST_IDLE : brcp_pkg::ST_MIX;
      default:           step_next = brcp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.step  = step;
    ctrl.ready = (step == brcp_pkg::ST_IDLE);
    ctrl.load  = (step == brcp_pkg::ST_MIX) && out_free;
  end

endmodule

// ===== hdl/balance_robot_cascade_pid_core.sv =====
// Channel  | Signals                        | Item
// ---------+--------------------------------+------------------------------------------
// s_*      | s_tvalid s_tready s_tdata[103:0] | one 10 ms tick of sensor and remote data
// m_*      | m_tvalid m_tready m_tdata[31:0]  | left/right drive pair
// APB      | psel penable pwrite paddr pwdata | eight gain/limit registers at 4*index
//
// An item is accepted in IDLE and then passes through 14 sequencer steps,
// eight of which feed the one shared multiplier.
// s_tready is high only in IDLE; a finished result waits in the output register
// and the sequencer holds in its last step only if that register is still full.
// Synchronous active-high reset clears the targets, filter and integral state,
// the sequencer and the output valid; registers return to their reset values.
module balance_robot_cascade_pid_core #(
  parameter int SPEED_TARGET_LIMIT = 12,
  parameter int TURN_TARGET_LIMIT  = 150,
  parameter int INTEGRAL_LIMIT     = 20000
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata, low bit up: left_count[15:0], right_count_raw[31:16],
  // roll_angle[48:32], rate_x[64:49], rate_z[80:65], cmd_forward[81],
  // cmd_backward[82], cmd_left[83], cmd_right[84], obstacle_distance[100:85],
  // clear_integral[101], zero pad[103:102]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [brcp_pkg::IN_W-1:0]         s_tdata,
  // m_tdata, low bit up: left_drive[15:0], right_drive[31:16]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [brcp_pkg::OUT_W-1:0]        m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [brcp_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int MA = brcp_pkg::MUL_A_W;
  localparam int MB = brcp_pkg::MUL_B_W;
  localparam int PW = brcp_pkg::PROD_W;

  brcp_pkg::cfg_t  cfg;
  brcp_pkg::ctrl_t ctrl;

  // ---------------------------------------------------------------- input fields
  logic signed [15:0] left_count, right_count_raw, rate_x, rate_z;
  logic signed [16:0] roll_angle;
  logic               cmd_forward, cmd_backward, cmd_left, cmd_right, clear_integral;
  logic [15:0]        obstacle_distance;

  assign left_count        = $signed(s_tdata[15:0]);
  assign right_count_raw   = $signed(s_tdata[31:16]);
  assign roll_angle        = $signed(s_tdata[48:32]);
  assign rate_x            = $signed(s_tdata[64:49]);
  assign rate_z            = $signed(s_tdata[80:65]);
  assign cmd_forward       = s_tdata[81];
  assign cmd_backward      = s_tdata[82];
  assign cmd_left          = s_tdata[83];
  assign cmd_right         = s_tdata[84];
  assign obstacle_distance = s_tdata[100:85];
  assign clear_integral    = s_tdata[101];

  // ---------------------------------------------------------------- state
  logic signed [brcp_pkg::ST_W-1:0]   speed_target;
  logic signed [brcp_pkg::TT_W-1:0]   turn_target;
  logic signed [brcp_pkg::FE_W-1:0]   filtered_error;
  logic signed [brcp_pkg::SI_W-1:0]   speed_integral;

  // per-item working registers
  logic signed [brcp_pkg::ERR_W-1:0]  err;
  logic signed [16:0]                 roll;
  logic signed [15:0]                 gx, gz;
  logic                               turning, clr;
  logic signed [PW-1:0]               acc;
  logic signed [brcp_pkg::TURN_W-1:0] turn_term;
  logic                               vneg;
  logic [brcp_pkg::VX_W-1:0]          vx;
  logic [brcp_pkg::VQ_W-1:0]          vq0;
  logic signed [brcp_pkg::VEL_W-1:0]  vel;
  logic signed [brcp_pkg::DIFF_W-1:0] diff;
  logic signed [brcp_pkg::UP_W-1:0]   upright;
  logic signed [brcp_pkg::DRV_W-1:0]  left_drive, right_drive;

  logic accept;
  assign accept   = s_tvalid & ctrl.ready;
  assign s_tready = ctrl.ready;

  // ---------------------------------------------------------------- target ramps
  logic signed [6:0]  st_base, st_sum, st_lim;
  logic signed [brcp_pkg::ST_W-1:0] st_next;
  logic signed [10:0] tt_base, tt_sum, tt_lim;
  logic signed [brcp_pkg::TT_W-1:0] tt_next;
  logic               near;

  assign near   = obstacle_distance < brcp_pkg::NEAR_DISTANCE;
  assign st_lim = 7'(SPEED_TARGET_LIMIT);
  assign tt_lim = 11'(TURN_TARGET_LIMIT);

  always_comb begin
    // no direction command drops the target to zero before the step
    st_base = (cmd_forward | cmd_backward) ? 7'(speed_target) : 7'sd0;
    st_sum  = st_base
            + (cmd_forward ? (near ? 7'sd1 : -7'sd1) : 7'sd0)
            + (cmd_backward ? 7'sd1 : 7'sd0);
    if (st_sum > st_lim) begin
      st_next = brcp_pkg::ST_W'(st_lim);
    end else if (st_sum < -st_lim) begin
      st_next = brcp_pkg::ST_W'(-st_lim);
    end else begin
      st_next = brcp_pkg::ST_W'(st_sum);
    end

    tt_base = (cmd_left | cmd_right) ? 11'(turn_target) : 11'sd0;
    tt_sum  = tt_base
            + (cmd_left  ? 11'(brcp_pkg::TURN_STEP) : 11'sd0)
            - (cmd_right ? 11'(brcp_pkg::TURN_STEP) : 11'sd0);
    if (tt_sum > tt_lim) begin
      tt_next = brcp_pkg::TT_W'(tt_lim);
    end else if (tt_sum < -tt_lim) begin
      tt_next = brcp_pkg::TT_W'(-tt_lim);
    end else begin
      tt_next = brcp_pkg::TT_W'(tt_sum);
    end
  end

  // ---------------------------------------------------------------- step helpers
  logic [8:0]                          alpha_eff, alpha_rest;
  logic signed [18:0]                  si_sum, si_lim;
  logic signed [brcp_pkg::SI_W-1:0]    si_next;
  logic signed [brcp_pkg::VSUM_W-1:0]  fe_w, vel_sum;
  logic signed [PW-1:0]                prod, prod_mag;
  logic [brcp_pkg::VX_W-1:0]           vq_fix, vrem;
  logic [brcp_pkg::VQ_W-1:0]           vq;
  logic signed [brcp_pkg::MIX_W-1:0]   lsum, rsum, plim;

  // alpha above 256 behaves as 256
  assign alpha_eff  = (cfg.filter_alpha > brcp_pkg::ALPHA_ONE) ?
                      brcp_pkg::ALPHA_ONE : cfg.filter_alpha;
  assign alpha_rest = brcp_pkg::ALPHA_ONE - alpha_eff;

  always_comb begin
    si_lim = 19'(INTEGRAL_LIMIT);
    si_sum = 19'(speed_integral) + 19'(filtered_error);
    if (clr) begin
      si_next = '0;
    end else if (si_sum > si_lim) begin
      si_next = brcp_pkg::SI_W'(si_lim);
    end else if (si_sum < -si_lim) begin
      si_next = brcp_pkg::SI_W'(-si_lim);
    end else begin
      si_next = brcp_pkg::SI_W'(si_sum);
    end
  end

  // 200*fe + si: PI numerator over speed_kp
  assign fe_w    = brcp_pkg::VSUM_W'(filtered_error);
  assign vel_sum = (fe_w <<< 7) + (fe_w <<< 6) + (fe_w <<< 3)
                 + brcp_pkg::VSUM_W'(speed_integral);

  assign prod_mag = prod[PW-1] ? -prod : prod;

  // reciprocal quotient is low by at most one
  assign vq_fix = (vq0 << 4) + (vq0 << 3) + brcp_pkg::VX_W'(vq0);
  assign vrem   = vx - vq_fix;
  assign vq     = (vrem >= brcp_pkg::VEL_DIV) ? vq0 + brcp_pkg::VQ_W'(1) : vq0;

  assign plim = brcp_pkg::MIX_W'($signed({1'b0, cfg.pwm_limit}));
  assign lsum = brcp_pkg::MIX_W'(upright) - brcp_pkg::MIX_W'(turn_term);
  assign rsum = brcp_pkg::MIX_W'(upright) + brcp_pkg::MIX_W'(turn_term);

  function automatic logic signed [brcp_pkg::DRV_W-1:0] clamp_drive(
    input logic signed [brcp_pkg::MIX_W-1:0] v,
    input logic signed [brcp_pkg::MIX_W-1:0] lim
  );
    if (v > lim) begin
      return brcp_pkg::DRV_W'(lim);
    end else if (v < -lim) begin
      return brcp_pkg::DRV_W'(-lim);
    end
    return brcp_pkg::DRV_W'(v);
  endfunction

  // ---------------------------------------------------------------- multiplier feed
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;

  always_comb begin
    case (ctrl.step)
      brcp_pkg::ST_FE0: begin   // (256 - alpha) * err
        mul_a = MA'(err);
        mul_b = MB'($signed({1'b0, alpha_rest}));
      end
      brcp_pkg::ST_FE1: begin   // alpha * previous filtered error
        mul_a = MA'(filtered_error);
        mul_b = MB'($signed({1'b0, alpha_eff}));
      end
      brcp_pkg::ST_FE: begin    // turn_kp * turn_target
        mul_a = MA'($signed({1'b0, cfg.turn_kp}));
        mul_b = MB'(turn_target);
      end
      brcp_pkg::ST_SI: begin    // damping off while a turn is commanded
        mul_a = MA'(gz);
        mul_b = turning ? '0 : MB'($signed({1'b0, cfg.turn_kd}));
      end
      brcp_pkg::ST_VEL0: begin
        mul_a = MA'(vel_sum);
        mul_b = MB'($signed({1'b0, cfg.speed_kp}));
      end
      brcp_pkg::ST_VEL2: begin  // quotient by 25 via reciprocal
        mul_a = MA'($signed({1'b0, vx}));
        mul_b = MB'($signed({1'b0, brcp_pkg::VEL_RECIP}));
      end
      brcp_pkg::ST_UP0: begin
        mul_a = MA'(diff);
        mul_b = MB'($signed({1'b0, cfg.upright_kp}));
      end
      brcp_pkg::ST_UP1: begin
        mul_a = MA'(gx);
        mul_b = MB'($signed({1'b0, cfg.upright_kd}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_target   <= '0;
      turn_target    <= '0;
      filtered_error <= '0;
      speed_integral <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        speed_target <= st_next;
        turn_target  <= tt_next;
      end
      if (ctrl.step == brcp_pkg::ST_FE) begin
        filtered_error <= brcp_pkg::FE_W'(brcp_pkg::sdiv_pow2(acc + prod, 6'd8));
      end
      if (ctrl.step == brcp_pkg::ST_SI) begin
        speed_integral <= si_next;
      end
      if (ctrl.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      err     <= brcp_pkg::ERR_W'(left_count) - brcp_pkg::ERR_W'(right_count_raw)
               - brcp_pkg::ERR_W'(st_next);
      roll    <= roll_angle;
      gx      <= rate_x;
      gz      <= rate_z;
      turning <= cmd_left | cmd_right;
      clr     <= clear_integral;
    end
    case (ctrl.step)
      brcp_pkg::ST_FE1:  acc <= prod;
      brcp_pkg::ST_SI:   acc <= prod;
      brcp_pkg::ST_VEL0: turn_term <= brcp_pkg::TURN_W'(brcp_pkg::sdiv_pow2(acc + prod, 6'd8));
      brcp_pkg::ST_VEL1: begin
        vneg <= prod[PW-1];
        vx   <= prod_mag[brcp_pkg::VEL_PRE_SHIFT +: brcp_pkg::VX_W];
      end
      brcp_pkg::ST_VEL3: vq0 <= prod[brcp_pkg::RECIP_SHIFT +: brcp_pkg::VQ_W];
      brcp_pkg::ST_VEL4: begin
        vel <= vneg ? -brcp_pkg::VEL_W'($signed({1'b0, vq}))
                    :  brcp_pkg::VEL_W'($signed({1'b0, vq}));
      end
      // setpoint = vel degrees in Q8.8 plus the balance offset
      brcp_pkg::ST_DIFF: begin
        diff <= brcp_pkg::DIFF_W'(roll) - (brcp_pkg::DIFF_W'(vel) <<< 8)
              - brcp_pkg::DIFF_W'(cfg.balance_offset);
      end
      brcp_pkg::ST_UP1:  acc <= prod;
      brcp_pkg::ST_UP2:  upright <= brcp_pkg::UP_W'(brcp_pkg::sdiv_pow2(acc + (prod <<< 8), 6'd16));
      default: ;
    endcase
    if (ctrl.load) begin
      left_drive  <= clamp_drive(lsum, plim);
      right_drive <= clamp_drive(rsum, plim);
    end
  end

  assign m_tdata = {right_drive, left_drive};

  // ---------------------------------------------------------------- sub-units
  brcp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (s_tvalid),
    .out_free (!m_tvalid || m_tready),
    .ctrl     (ctrl)
  );

  brcp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

endmodule

// ===== hdl/brcp_checker.sv =====
`include "balance_robot_cascade_pid_core_macros.svh"

module brcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // one item at a time: busy right after taking one
  `BRCP_ASSERT_CLK(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "item taken while busy")

  `BRCP_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

  // a result only shows up out of a busy sequencer
  `BRCP_ASSERT_CLK(a_out_after_work, $rose(m_tvalid) |-> $past(!s_tready), "result without work")

  // drive limit is symmetric, so the most negative code never appears
  `BRCP_ASSERT_NEVER(a_drive_sym, m_tvalid && (m_tdata[15:0] == 16'h8000 || m_tdata[31:16] == 16'h8000), "drive outside symmetric limit")

endmodule

bind balance_robot_cascade_pid_core brcp_checker u_brcp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/tb_balance_robot_cascade_pid_core.sv =====
`timescale 1ns / 1ps

module tb_balance_robot_cascade_pid_core;

  // Block parameters, passed to the instance so the predictor uses the same limits
  localparam int    SPD_LIM   = 12;
  localparam int    TURN_LIM  = 150;
  localparam int    INT_LIM   = 20000;
  localparam longint KI_DIV   = 200;   // integral gain = speed_kp / KI_DIV
  localparam int    SEG_ITEMS = 215;   // random ticks per register setting
  localparam int    SETTLE    = 20;    // quiet cycles after the last drive item
  localparam int    STALL_MAX = 3000;  // cycles with no handshake before giving up

  // One tick item, laid out exactly as s_tdata (last field in the low bits)
  typedef struct packed {
    logic [1:0]         pad;
    logic               clear_integral;
    logic [15:0]        obstacle_distance;
    logic               cmd_right;
    logic               cmd_left;
    logic               cmd_backward;
    logic               cmd_forward;
    logic signed [15:0] rate_z;
    logic signed [15:0] rate_x;
    logic signed [16:0] roll_angle;
    logic signed [15:0] right_count_raw;
    logic signed [15:0] left_count;
  } tick_t;

  // One drive item, laid out as m_tdata
  typedef struct packed {
    logic signed [15:0] right_drive;
    logic signed [15:0] left_drive;
  } drive_t;

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [brcp_pkg::IN_W-1:0]   s_tdata  = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [brcp_pkg::OUT_W-1:0]  m_tdata;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [brcp_pkg::ADDR_W-1:0] paddr    = '0;
  logic [31:0]                 pwdata   = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  balance_robot_cascade_pid_core #(
    .SPEED_TARGET_LIMIT(SPD_LIM),
    .TURN_TARGET_LIMIT (TURN_LIM),
    .INTEGRAL_LIMIT    (INT_LIM)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: our own copy of the gains and the controller state.
  // Updated once per accepted tick, in acceptance order.
  // ---------------------------------------------------------------------------
  brcp_pkg::cfg_t gains = brcp_pkg::CFG_RESET;
  longint speed_tgt = 0;
  longint turn_tgt  = 0;
  longint filt_err  = 0;
  longint speed_int = 0;

  drive_t expected_drives[$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int n_errors   = 0;
  int n_ticks    = 0;
  int n_drives   = 0;
  int n_settings = 0;

  // Held remote commands, so the ramps see long runs of the same button
  logic hold_fwd = 1'b0, hold_back = 1'b0, hold_left = 1'b0, hold_right = 1'b0;

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Runs one control tick through the cascade and returns the drive pair.
  // Every stage divides once, truncating toward zero (SV signed '/' does that).
  function automatic drive_t predict_drive(input tick_t t);
    longint lc, rc, roll, gx, gz;
    longint ukp, ukd, skp, alpha, tkp, kd, ofs, lim;
    longint err, vel, setpt, upright, turn;
    drive_t d;
    lc   = t.left_count;
    rc   = t.right_count_raw;
    roll = t.roll_angle;
    gx   = t.rate_x;
    gz   = t.rate_z;
    ukp  = gains.upright_kp;
    ukd  = gains.upright_kd;
    skp  = gains.speed_kp;
    tkp  = gains.turn_kp;
    ofs  = gains.balance_offset;
    lim  = gains.pwm_limit;
    alpha = gains.filter_alpha;
    // above one: filter just holds
    if (alpha > brcp_pkg::ALPHA_ONE) alpha = brcp_pkg::ALPHA_ONE;

    // Speed ramp: forward moves toward the obstacle side, both buttons add up
    if (!t.cmd_forward && !t.cmd_backward) speed_tgt = 0;
    if (t.cmd_forward)
      speed_tgt += (t.obstacle_distance < brcp_pkg::NEAR_DISTANCE) ? 1 : -1;
    if (t.cmd_backward) speed_tgt += 1;
    speed_tgt = clip(speed_tgt, SPD_LIM);

    // Turn ramp: left and right together cancel
    if (!t.cmd_left && !t.cmd_right) turn_tgt = 0;
    if (t.cmd_left) turn_tgt += brcp_pkg::TURN_STEP;
    if (t.cmd_right) turn_tgt -= brcp_pkg::TURN_STEP;
    turn_tgt = clip(turn_tgt, TURN_LIM);
    kd = (t.cmd_left || t.cmd_right) ? 0 : longint'(gains.turn_kd);

    // Velocity PI; right count is negated inside, so err = left - raw right
    err       = lc - rc - speed_tgt;
    filt_err  = ((256 - alpha) * err + alpha * filt_err) / 256;
    speed_int = clip(speed_int + filt_err, INT_LIM);
    if (t.clear_integral) speed_int = 0;
    vel = (KI_DIV * skp * filt_err + skp * speed_int) / (256 * KI_DIV);

    // Upright PD around vel (whole degrees) plus offset, then turn PD
    setpt   = vel * 256 + ofs;
    upright = (ukp * (roll - setpt) + 256 * ukd * gx) / 65536;
    turn    = (tkp * turn_tgt + kd * gz) / 256;

    d.left_drive  = 16'(clip(upright - turn, lim));
    d.right_drive = 16'(clip(upright + turn, lim));
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Random tick source. Buttons are held and flipped now and then; sensor
  // values are mostly plausible with a share of full-range noise.
  // ---------------------------------------------------------------------------
  function automatic tick_t gen_tick();
    tick_t t;
    t = '0;
    if ($urandom_range(9) == 0) hold_fwd   = ($urandom_range(4) < 2);
    if ($urandom_range(9) == 0) hold_back  = ($urandom_range(4) < 2);
    if ($urandom_range(9) == 0) hold_left  = ($urandom_range(4) < 2);
    if ($urandom_range(9) == 0) hold_right = ($urandom_range(4) < 2);
    t.cmd_forward  = hold_fwd;
    t.cmd_backward = hold_back;
    t.cmd_left     = hold_left;
    t.cmd_right    = hold_right;

    case ($urandom_range(9))
      0, 1, 2: t.obstacle_distance = 16'($urandom_range(40, 60));  // around near
      3, 4:    t.obstacle_distance = 16'($urandom_range(49));
      default: t.obstacle_distance = 16'($urandom);
    endcase

    if ($urandom_range(3) == 0) begin
      t.left_count      = 16'($urandom);
      t.right_count_raw = 16'($urandom);
    end else begin
      t.left_count      = 16'($urandom_range(400) - 200);
      t.right_count_raw = 16'($urandom_range(400) - 200);
    end

    case ($urandom_range(9))
      0:       t.roll_angle = 17'($urandom);                     // beyond +-180 deg
      1, 2:    t.roll_angle = 17'($urandom_range(4000) - 2000);
      default: t.roll_angle = 17'($urandom_range(92160) - 46080);
    endcase

    t.rate_x = ($urandom_range(4) < 2) ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
    t.rate_z = ($urandom_range(4) < 2) ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
    t.clear_integral = ($urandom_range(29) == 0);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All inputs change on the falling edge; every task is entered and
  // left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_drives.push_back(predict_drive(t));
    n_ticks++;
    @(negedge clk);
  endtask

  // Register write; upper pwdata bits carry junk the block must drop
  task automatic write_reg(input brcp_pkg::reg_idx_t idx, input logic [31:0] val,
                           input int w);
    logic [31:0] mask;
    mask    = (32'd1 << w) - 32'd1;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom & ~mask) | (val & mask);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Wait until every drive item is back and the sequencer has gone quiet
  task automatic drain_drives();
    s_tvalid = 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_settings(input brcp_pkg::cfg_t c);
    drain_drives();
    write_reg(brcp_pkg::REG_UPRIGHT_KP,     32'(c.upright_kp),     18);
    write_reg(brcp_pkg::REG_UPRIGHT_KD,     32'(c.upright_kd),     12);
    write_reg(brcp_pkg::REG_SPEED_KP,       32'(c.speed_kp),       10);
    write_reg(brcp_pkg::REG_FILTER_ALPHA,   32'(c.filter_alpha),   9);
    write_reg(brcp_pkg::REG_TURN_KP,        32'(c.turn_kp),        16);
    write_reg(brcp_pkg::REG_TURN_KD,        32'(c.turn_kd),        12);
    write_reg(brcp_pkg::REG_BALANCE_OFFSET, 32'(c.balance_offset), 17);
    write_reg(brcp_pkg::REG_PWM_LIMIT,      32'(c.pwm_limit),      15);
    gains = c;
    n_settings++;
  endtask

  task automatic run_random(input int n);
    repeat (n) send_tick(gen_tick());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random back-pressure and the drive item checker
  // ---------------------------------------------------------------------------
  always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin : drive_check
    drive_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      n_drives++;
      if (expected_drives.size() == 0) begin
        $error("drive item with no tick pending: %h", m_tdata);
        n_errors++;
      end else begin
        want = expected_drives.pop_front();
        if (got.left_drive !== want.left_drive) begin
          $error("left_drive: expected %0d, got %0d", want.left_drive, got.left_drive);
          n_errors++;
        end
        if (got.right_drive !== want.right_drive) begin
          $error("right_drive: expected %0d, got %0d", want.right_drive, got.right_drive);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: any stream handshake or register write restarts the count
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every button, both opposing button pairs, turn ramp clamp, integral clear
  task automatic test_directed();
    tick_t t;
    t = '0;
    send_tick(t);
    // Largest positive speed error, full tilt and rates
    t.left_count = 16'h7fff;  t.right_count_raw = 16'h8000;  t.roll_angle = 17'sd46080;
    t.rate_x = 16'h7fff;  t.rate_z = 16'h7fff;  t.obstacle_distance = 16'hffff;
    send_tick(t);
    t.left_count = 16'h8000;  t.right_count_raw = 16'h7fff;  t.roll_angle = -17'sd46080;
    t.rate_x = 16'h8000;  t.rate_z = 16'h8000;  t.obstacle_distance = 16'h0000;
    send_tick(t);
    // Forward just inside and at the near threshold, then far away
    t = '0;
    t.cmd_forward = 1'b1;
    t.obstacle_distance = 16'd49;    send_tick(t);
    t.obstacle_distance = 16'd50;    send_tick(t);
    t.obstacle_distance = 16'hffff;  send_tick(t);
    // Backward alone, then forward and backward together
    t.cmd_forward = 1'b0;  t.cmd_backward = 1'b1;  send_tick(t);
    t.cmd_forward = 1'b1;  send_tick(t);
    // Releasing the buttons drops both targets
    t = '0;
    send_tick(t);
    // Left held past the turn limit
    t.cmd_left = 1'b1;
    t.rate_z = 16'h7fff;
    repeat (6) send_tick(t);
    // Both turn buttons: steps cancel, damping stays off
    t.cmd_right = 1'b1;  send_tick(t);
    t.cmd_left  = 1'b0;  send_tick(t);
    // Wind the integral up, then clear it
    t = '0;
    t.left_count = 16'h4000;  t.right_count_raw = 16'hc000;
    send_tick(t);
    t.clear_integral = 1'b1;  send_tick(t);
    // Tilt readings beyond +-180 degrees
    t = '0;
    t.roll_angle = 17'h10000;  send_tick(t);
    t.roll_angle = 17'h0ffff;  send_tick(t);
  endtask

  task automatic test_reset_gains();
    write_settings(brcp_pkg::CFG_RESET);
    run_random(SEG_ITEMS);
  endtask

  // Every gain at full scale, alpha above one, +180 degree offset and largest limit
  task automatic test_max_gains();
    brcp_pkg::cfg_t c;
    c.upright_kp     = '1;
    c.upright_kd     = '1;
    c.speed_kp       = '1;
    c.filter_alpha   = 9'd511;
    c.turn_kp        = '1;
    c.turn_kd        = '1;
    c.balance_offset = 17'sd46080;
    c.pwm_limit      = 15'd32767;
    write_settings(c);
    run_random(SEG_ITEMS);
  endtask

  // Gains off, no filtering, -180 degree offset, zero drive limit
  task automatic test_min_gains();
    brcp_pkg::cfg_t c;
    c = '0;
    c.balance_offset = -17'sd46080;
    write_settings(c);
    run_random(SEG_ITEMS);
  endtask

  task automatic test_random_gains();
    brcp_pkg::cfg_t c;
    c.upright_kp = ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(60000));
    c.upright_kd = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(600));
    c.speed_kp   = 10'($urandom);
    case ($urandom_range(3))
      0:       c.filter_alpha = 9'd0;
      1:       c.filter_alpha = brcp_pkg::ALPHA_ONE;
      2:       c.filter_alpha = 9'($urandom);
      default: c.filter_alpha = 9'($urandom_range(255));
    endcase
    c.turn_kp = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6000));
    c.turn_kd = 12'($urandom);
    c.balance_offset = ($urandom_range(4) == 0) ? 17'($urandom)
                                                : 17'($urandom_range(92160) - 46080);
    c.pwm_limit = ($urandom_range(4) == 0) ? 15'd32767 : 15'($urandom_range(32767));
    write_settings(c);
    run_random(SEG_ITEMS);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Slow consumer first
    src_idle_pct  = 11;
    sink_idle_pct = 86;
    test_directed();
    test_reset_gains();
    test_max_gains();

    // Then a slow producer
    src_idle_pct  = 86;
    sink_idle_pct = 11;
    test_min_gains();
    test_random_gains();

    // Back to back
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_gains();
    test_random_gains();

    drain_drives();
    $display("Checked %0d drive items from %0d ticks over %0d register settings.",
             n_drives, n_ticks, n_settings + 1);
    $display("Ramps, clamps, integral clear, alpha above one, wide offsets and stalls hit.");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== balance_robot_cascade_pid_core.f =====
+incdir+hdl
hdl/brcp_pkg.sv
hdl/brcp_regs.sv
hdl/brcp_mul.sv
hdl/brcp_ctrl.sv
hdl/balance_robot_cascade_pid_core.sv
hdl/brcp_checker.sv
sim/tb_balance_robot_cascade_pid_core.sv
